>>> src/sliding_window_sender_unit_macros.svh
// Assertion macros for the sliding window sender unit.
// Included by the top level; no other dependencies.
`ifndef SLIDING_WINDOW_SENDER_UNIT_MACROS_SVH
`define SLIDING_WINDOW_SENDER_UNIT_MACROS_SVH

// same-cycle implication
`define SWSU_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swsu: same-cycle check failed");

// next-cycle implication
`define SWSU_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swsu: next-cycle check failed");

`endif

>>> src/swsu_pkg.sv
// Shared types and constants for the sliding window sender unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package swsu_pkg;

   localparam int MAX_RESULTS = 32;
   localparam int COUNT_W     = 6;
   localparam int SLOT_W_MAX  = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;
   localparam int QUEUE_CNT_W = 2;

   localparam logic [5:0] WINDOW_RESET = 6'd32;
   localparam logic [1:0] ACK_TYPE_ACK = 2'd3;

   typedef enum logic [1:0] {
      MODE_OFFER   = 2'd0,
      MODE_ACK     = 2'd1,
      MODE_TIMEOUT = 2'd2,
      MODE_NONE    = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      KIND_SENT        = 3'd0,
      KIND_REFUSED     = 3'd1,
      KIND_ACK_TAKEN   = 3'd2,
      KIND_ACK_IGNORED = 3'd3,
      KIND_RESEND      = 3'd4,
      KIND_EMPTY       = 3'd5
   } kind_type;

   typedef enum logic {
      BACK_IDLE = 1'b0,
      BACK_WALK = 1'b1
   } back_state_type;

   typedef struct packed {
      mode_type    mode;
      logic [10:0] seg_length;
      logic [31:0] seg_checksum;
      logic [1:0]  ack_type;
      logic [31:0] ack_seq;
   } req_item_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] seq_num;
      logic [10:0] out_length;
      logic [31:0] out_checksum;
      logic [31:0] window_base;
      logic        last;
   } rsp_item_type;

   typedef struct packed {
      kind_type               kind;
      logic [31:0]            seq;
      logic [10:0]            length;
      logic [31:0]            checksum;
      logic [31:0]            base;
      logic [SLOT_W_MAX-1:0]  slot;
      logic [COUNT_W-1:0]     count;
   } cmd_type;

   typedef struct packed {
      logic [10:0] length;
      logic [31:0] checksum;
   } slot_entry_type;

endpackage

`default_nettype wire

>>> src/swsu_front.sv
// Front end: takes items, holds window state and the window register, classifies
// each event into a command for the back end. Depends on swsu_pkg.
`default_nettype none

module swsu_front
   import swsu_pkg::*;
#(
   parameter int WINDOW_MAX  = 32,
   parameter int MAX_PAYLOAD = 1456
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [5:0]   csr_wr_data,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_item,
   output logic              push_valid,
   input  wire logic         push_ready,
   output cmd_type           push_cmd
);

   localparam int SW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int SUMW = SW + 1;

   logic [5:0]    window_ff, window_in;
   logic [31:0]   base_ff, base_in;
   logic [31:0]   next_ff, next_in;
   logic [SW-1:0] base_slot_ff, base_slot_in;
   logic [SW-1:0] next_slot_ff, next_slot_in;

   logic [31:0]   outstanding;
   logic [31:0]   eff_window;
   logic          full;
   logic [10:0]   len_sat;
   logic [31:0]   advance;
   logic          ack_ok;
   logic [SUMW-1:0] slot_sum;
   logic [SW-1:0] ack_slot;
   logic [COUNT_W-1:0] resend_count;
   logic          accept;

   assign req_ready   = push_ready;
   assign accept      = req_valid && req_ready;
   assign outstanding = next_ff - base_ff;
   assign full        = outstanding >= eff_window;
   assign advance     = req_item.ack_seq - base_ff;
   assign ack_ok      = (req_item.ack_type == ACK_TYPE_ACK) && (advance != 32'd0) &&
                        (advance <= outstanding);
   assign slot_sum    = SUMW'(base_slot_ff) + advance[SUMW-1:0];

   always_comb begin
      if (window_ff == 6'd0) begin
         eff_window = 32'd1;
      end else if (32'(window_ff) > 32'(WINDOW_MAX)) begin
         eff_window = 32'(WINDOW_MAX);
      end else begin
         eff_window = 32'(window_ff);
      end
   end

   always_comb begin
      if (32'(req_item.seg_length) > 32'(MAX_PAYLOAD)) begin
         len_sat = 11'(MAX_PAYLOAD);
      end else begin
         len_sat = req_item.seg_length;
      end
   end

   // wrap past zero restarts the slot at the low bits of the ack
   always_comb begin
      if (req_item.ack_seq < base_ff) begin
         ack_slot = req_item.ack_seq[SW-1:0];
      end else if (slot_sum >= SUMW'(WINDOW_MAX)) begin
         ack_slot = SW'(slot_sum - SUMW'(WINDOW_MAX));
      end else begin
         ack_slot = slot_sum[SW-1:0];
      end
   end

   always_comb begin
      if (outstanding > 32'(MAX_RESULTS)) begin
         resend_count = COUNT_W'(MAX_RESULTS);
      end else begin
         resend_count = outstanding[COUNT_W-1:0];
      end
   end

   always_comb begin
      push_cmd      = '0;
      push_cmd.base = base_ff;
      push_valid    = 1'b0;
      unique case (req_item.mode)
         MODE_OFFER: begin
            push_valid = req_valid;
            if (full) begin
               push_cmd.kind = KIND_REFUSED;
            end else begin
               push_cmd.kind     = KIND_SENT;
               push_cmd.seq      = next_ff;
               push_cmd.length   = len_sat;
               push_cmd.checksum = req_item.seg_checksum;
               push_cmd.slot     = SLOT_W_MAX'(next_slot_ff);
            end
         end
         MODE_ACK: begin
            push_valid = req_valid;
            if (ack_ok) begin
               push_cmd.kind = KIND_ACK_TAKEN;
               push_cmd.base = req_item.ack_seq;
            end else begin
               push_cmd.kind = KIND_ACK_IGNORED;
            end
         end
         MODE_TIMEOUT: begin
            push_valid = req_valid;
            if (outstanding == 32'd0) begin
               push_cmd.kind = KIND_EMPTY;
            end else begin
               push_cmd.kind  = KIND_RESEND;
               push_cmd.seq   = base_ff;
               push_cmd.slot  = SLOT_W_MAX'(base_slot_ff);
               push_cmd.count = resend_count;
            end
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

   always_comb begin
      window_in    = csr_wr_en ? csr_wr_data : window_ff;
      base_in      = base_ff;
      base_slot_in = base_slot_ff;
      next_in      = next_ff;
      next_slot_in = next_slot_ff;
      if (accept && (req_item.mode == MODE_OFFER) && !full) begin
         next_in = next_ff + 32'd1;
         if ((next_ff == 32'hFFFF_FFFF) || (next_slot_ff == SW'(WINDOW_MAX - 1))) begin
            next_slot_in = '0;
         end else begin
            next_slot_in = next_slot_ff + SW'(1);
         end
      end
      if (accept && (req_item.mode == MODE_ACK) && ack_ok) begin
         base_in      = req_item.ack_seq;
         base_slot_in = ack_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         base_ff      <= '0;
         next_ff      <= '0;
         base_slot_ff <= '0;
         next_slot_ff <= '0;
      end else begin
         window_ff    <= window_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         base_slot_ff <= base_slot_in;
         next_slot_ff <= next_slot_in;
      end
   end

endmodule

`default_nettype wire

>>> src/swsu_queue.sv
// Short command queue between front and back end.
// Depends on swsu_pkg for the command type and depth.
`default_nettype none

module swsu_queue
   import swsu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_cmd
);

   cmd_type                  entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                     do_push, do_pop;

   assign push_ready = count_ff != QUEUE_CNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     wr_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                     rd_ptr_ff + QUEUE_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> src/swsu_back.sv
// Back end: carries out commands, stores segments in the slot memory, walks
// outstanding slots on a resend and drives the result register. Depends on swsu_pkg.
`default_nettype none

module swsu_back
   import swsu_pkg::*;
#(
   parameter int WINDOW_MAX = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   output logic         cmd_pop,
   input  wire cmd_type cmd,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_item_type rsp_item
);

   localparam int SW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   slot_entry_type     slot_mem [WINDOW_MAX];
   slot_entry_type     rd_data_ff;

   back_state_type     state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_item_ff, rsp_item_in;
   logic [31:0]        walk_seq_ff, walk_seq_in;
   logic [SW-1:0]      walk_slot_ff, walk_slot_in;
   logic [COUNT_W-1:0] walk_left_ff, walk_left_in;
   logic [31:0]        walk_base_ff, walk_base_in;

   logic               can_load;
   logic               rsp_load;
   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [SW-1:0]      mem_rd_addr;
   logic [SW-1:0]      slot_step;
   logic               walk_last;

   assign can_load  = !rsp_valid_ff || rsp_ready;
   assign walk_last = walk_left_ff == COUNT_W'(1);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // wrap of the sequence number or of the last slot index restarts at slot zero
   assign slot_step = ((walk_seq_ff == 32'hFFFF_FFFF) ||
                       (walk_slot_ff == SW'(WINDOW_MAX - 1))) ? '0 :
                      walk_slot_ff + SW'(1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid && can_load && (cmd.kind == KIND_RESEND)) begin
               state_in = BACK_WALK;
            end
         end
         BACK_WALK: begin
            if (can_load && walk_last) begin
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd_pop      = 1'b0;
      rsp_load     = 1'b0;
      rsp_item_in  = rsp_item_ff;
      mem_wr_en    = 1'b0;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = walk_slot_ff;
      walk_seq_in  = walk_seq_ff;
      walk_slot_in = walk_slot_ff;
      walk_left_in = walk_left_ff;
      walk_base_in = walk_base_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (cmd_valid && can_load) begin
               cmd_pop = 1'b1;
               if (cmd.kind == KIND_RESEND) begin
                  mem_rd_en    = 1'b1;
                  mem_rd_addr  = cmd.slot[SW-1:0];
                  walk_seq_in  = cmd.seq;
                  walk_slot_in = cmd.slot[SW-1:0];
                  walk_left_in = cmd.count;
                  walk_base_in = cmd.base;
               end else begin
                  rsp_load                 = 1'b1;
                  rsp_item_in.kind         = cmd.kind;
                  rsp_item_in.seq_num      = cmd.seq;
                  rsp_item_in.out_length   = cmd.length;
                  rsp_item_in.out_checksum = cmd.checksum;
                  rsp_item_in.window_base  = cmd.base;
                  rsp_item_in.last         = 1'b1;
                  mem_wr_en                = cmd.kind == KIND_SENT;
               end
            end
         end
         BACK_WALK: begin
            if (can_load) begin
               rsp_load                 = 1'b1;
               rsp_item_in.kind         = KIND_RESEND;
               rsp_item_in.seq_num      = walk_seq_ff;
               rsp_item_in.out_length   = rd_data_ff.length;
               rsp_item_in.out_checksum = rd_data_ff.checksum;
               rsp_item_in.window_base  = walk_base_ff;
               rsp_item_in.last         = walk_last;
               mem_rd_en                = 1'b1;
               mem_rd_addr              = slot_step;
               walk_seq_in              = walk_seq_ff + 32'd1;
               walk_slot_in             = slot_step;
               walk_left_in             = walk_left_ff - COUNT_W'(1);
            end
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         slot_mem[cmd.slot[SW-1:0]] <= '{length: cmd.length, checksum: cmd.checksum};
      end
      if (mem_rd_en) begin
         rd_data_ff <= slot_mem[mem_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_item_ff <= rsp_item_in;
      end
      walk_seq_ff  <= walk_seq_in;
      walk_slot_ff <= walk_slot_in;
      walk_base_ff <= walk_base_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         walk_left_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         walk_left_ff <= walk_left_in;
      end
   end

endmodule

`default_nettype wire

>>> src/sliding_window_sender_unit.sv
// Go-back-N sender window control, top level.
// Usage:
//   req_* carries one event per item: offer a segment, an acknowledgement or a
//   retransmission timeout; rsp_* returns the results, last marks the final one.
//   csr_wr_en/csr_wr_data write the window size; the user must write it only while
//   the block is idle, as the block itself does not enforce this.
// Path: a result passes the command queue, then the result register; the first
//   resent segment of a timeout also the slot memory read register between them.
// Throughput: offers and acks, one item per cycle while results are taken and no
//   resend is walked. A timeout resends n segments (at most 32): a slot memory read
//   first, then one result per cycle from the single read port unless rsp_ready is low.
// A two-entry command queue lets the front take items while the back end walks
//   a resend or the receiver holds rsp_ready low; req_ready falls only when the
//   queue is full. The result register holds its item until it is taken.
// Reset: window size 32, base and next sequence numbers zero, queue and result
//   register empty. Slot memory is not cleared; only written slots are read.
// Depends on swsu_pkg, swsu_front, swsu_queue, swsu_back and the macro header.
`default_nettype none
`include "sliding_window_sender_unit_macros.svh"

module sliding_window_sender_unit
   import swsu_pkg::*;
#(
   parameter int WINDOW_MAX  = 32,
   parameter int MAX_PAYLOAD = 1456
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [5:0]   csr_wr_data,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_item
);

   logic    push_valid, push_ready;
   cmd_type push_cmd;
   logic    pop_valid, pop_ready;
   cmd_type pop_cmd;

   swsu_front #(
      .WINDOW_MAX  (WINDOW_MAX),
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_cmd    (push_cmd)
   );

   swsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   swsu_back #(
      .WINDOW_MAX (WINDOW_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (pop_valid),
      .cmd_pop   (pop_ready),
      .cmd       (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   `SWSU_ASSERT_IMP(a_single_is_last, clock, reset,
      rsp_valid && (rsp_item.kind != KIND_RESEND), rsp_item.last)
   `SWSU_ASSERT_IMP(a_sent_in_window, clock, reset,
      rsp_valid && (rsp_item.kind == KIND_SENT),
      (rsp_item.seq_num - rsp_item.window_base) < 32'(WINDOW_MAX))
   `SWSU_ASSERT_NEXT(a_resend_burst, clock, reset,
      rsp_valid && rsp_ready && (rsp_item.kind == KIND_RESEND) && !rsp_item.last,
      rsp_valid && (rsp_item.kind == KIND_RESEND) &&
      (rsp_item.seq_num == $past(rsp_item.seq_num) + 32'd1))

endmodule

`default_nettype wire
